/* hdl/u8s_pkg.sv */
// Package for the UTF-8 sanitizer: constants, packet type and lead classifier.
// No dependencies; used by every design module of the block but the checker.
`default_nettype none

package u8s_pkg;

    localparam logic [7:0] QMARK = 8'h3F;
    localparam int QDEPTH = 4;
    localparam int QPTRW = $clog2(QDEPTH);
    localparam int QCNTW = $clog2(QDEPTH + 1);

    typedef logic [7:0] byte_t;

    // Up to four result bytes caused by one input byte.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [3:0]      repl;
        logic [1:0]      last;
        logic            fin;
    } pkt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            if ((b & 8'h80) == 8'h00)
            begin
                len = 3'd1;
            end
            else if ((b & 8'hE0) == 8'hC0)
            begin
                len = 3'd2;
            end
            else if ((b & 8'hF0) == 8'hE0)
            begin
                len = 3'd3;
            end
            else if ((b & 8'hF8) == 8'hF0)
            begin
                len = 3'd4;
            end
            else
            begin
                len = 3'd0;
            end
            return len;
        end
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

endpackage

`default_nettype wire

/* hdl/u8s_if.sv */
// Channel interfaces for the UTF-8 sanitizer: raw byte input and cleaned byte output.
// No dependencies.
`default_nettype none

interface u8s_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_end;

    modport source (output valid, output in_byte, output in_end, input ready);
    modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

interface u8s_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output was_replaced,
                    output run_last, output string_end, input ready);
    modport sink (input valid, input out_byte, input was_replaced,
                  input run_last, input string_end, output ready);
endinterface

`default_nettype wire

/* hdl/utf8_sanitizer_core.sv */
// UTF-8 sanitizer top level: front end, packet queue and back end.
// Depends on u8s_pkg, u8s_if, u8s_front, u8s_queue and u8s_back.
//
// Accepts one raw byte per cycle unless the queue is full and delivers one
// cleaned byte per cycle unless the output stalls. Each byte is classified
// in the cycle it is accepted; a byte that completes or breaks a sequence
// produces a packet of one to four output bytes, which enters a four-entry
// queue and is shifted out one byte per transfer. A byte that only extends a
// pending sequence produces nothing until the sequence ends. Input ready drops
// only when the queue holds four packets, so the output port bounds throughput
// at one byte per cycle, matching the stream's one-byte-per-byte average.
`default_nettype none

module utf8_sanitizer_core (
    input  wire logic clk,
    input  wire logic rst_n,
    u8s_in_if.sink    raw,
    u8s_out_if.source clean
);

    logic               push;
    logic               pop;
    u8s_pkg::pkt_t      push_pkt;
    u8s_pkg::pkt_t      head;
    u8s_pkg::q_status_t q_stat;

    u8s_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .q_stat   (q_stat),
        .push     (push),
        .push_pkt (push_pkt)
    );

    u8s_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_pkt (push_pkt),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    u8s_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .clean    (clean)
    );

endmodule

`default_nettype wire

/* hdl/u8s_front.sv */
// Front end: accepts bytes, tracks the pending sequence, builds result packets.
// Depends on u8s_pkg and u8s_in_if.
`default_nettype none

module u8s_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    u8s_in_if.sink                 raw,
    input  wire u8s_pkg::q_status_t q_stat,
    output      logic              push,
    output      u8s_pkg::pkt_t     push_pkt
);

    logic [1:0]  hc_reg, hc_next;
    logic [2:0]  el_reg, el_next;
    logic [7:0]  hb_reg [3];
    logic [7:0]  hb_next [3];
    logic        accept;
    logic [2:0]  n;
    logic        consumed;
    logic [2:0]  len;
    u8s_pkg::pkt_t pkt;

    assign raw.ready = !q_stat.full;
    assign accept    = raw.valid && raw.ready;

    always_comb
    begin
        pkt      = '0;
        n        = 3'd0;
        consumed = 1'b0;
        hc_next  = hc_reg;
        el_next  = el_reg;
        hb_next  = hb_reg;
        len      = u8s_pkg::seq_len(raw.in_byte);

        if (hc_reg != 2'd0)
        begin
            if (u8s_pkg::is_cont(raw.in_byte))
            begin
                consumed = 1'b1;
                if ({1'b0, hc_reg} + 3'd1 >= el_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < hc_reg)
                        begin
                            pkt.data[n[1:0]] = hb_reg[i];
                            n = n + 3'd1;
                        end
                    end
                    pkt.data[n[1:0]] = raw.in_byte;
                    n       = n + 3'd1;
                    hc_next = 2'd0;
                    el_next = 3'd0;
                end
                else
                begin
                    hb_next[hc_reg] = raw.in_byte;
                    hc_next         = hc_reg + 2'd1;
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < hc_reg)
                    begin
                        pkt.data[n[1:0]] = u8s_pkg::QMARK;
                        pkt.repl[n[1:0]] = 1'b1;
                        n = n + 3'd1;
                    end
                end
                hc_next = 2'd0;
                el_next = 3'd0;
            end
        end

        if (!consumed)
        begin
            case (len)
                3'd0:
                begin
                    pkt.data[n[1:0]] = u8s_pkg::QMARK;
                    pkt.repl[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                end
                3'd1:
                begin
                    pkt.data[n[1:0]] = raw.in_byte;
                    n = n + 3'd1;
                end
                default:
                begin
                    hb_next[0] = raw.in_byte;
                    hc_next    = 2'd1;
                    el_next    = len;
                end
            endcase
        end

        if (raw.in_end && hc_next != 2'd0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < hc_next)
                begin
                    pkt.data[n[1:0]] = u8s_pkg::QMARK;
                    pkt.repl[n[1:0]] = 1'b1;
                    n = n + 3'd1;
                end
            end
            hc_next = 2'd0;
            el_next = 3'd0;
        end

        pkt.last = 2'(n - 3'd1);
        pkt.fin  = raw.in_end;
    end

    assign push     = accept && (n != 3'd0);
    assign push_pkt = pkt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 2'd0;
            el_reg <= 3'd0;
        end
        else if (accept)
        begin
            hc_reg <= hc_next;
            el_reg <= el_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hb_reg <= hb_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/u8s_queue.sv */
// Packet queue between front and back end, QDEPTH entries.
// Depends on u8s_pkg.
`default_nettype none

module u8s_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire u8s_pkg::pkt_t      push_pkt,
    input  wire logic               pop,
    output      u8s_pkg::pkt_t      head,
    output      u8s_pkg::q_status_t stat
);

    u8s_pkg::pkt_t                  mem_reg [u8s_pkg::QDEPTH];
    logic [u8s_pkg::QPTRW-1:0]      wr_ptr_reg;
    logic [u8s_pkg::QPTRW-1:0]      rd_ptr_reg;
    logic [u8s_pkg::QCNTW-1:0]      count_reg;

    assign stat.full  = (count_reg == u8s_pkg::QCNTW'(u8s_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_pkt;
        end
    end

endmodule

`default_nettype wire

/* hdl/u8s_back.sv */
// Back end: serializes queued packets into one output byte per transfer.
// Depends on u8s_pkg and u8s_out_if.
`default_nettype none

module u8s_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u8s_pkg::pkt_t      head,
    input  wire u8s_pkg::q_status_t q_stat,
    output      logic               pop,
    u8s_out_if.source               clean
);

    u8s_pkg::pkt_t pkt_reg;
    logic [1:0]    idx_reg;
    logic          busy_reg;
    logic          done;
    logic          is_last;

    assign is_last = (idx_reg == pkt_reg.last);
    assign done    = busy_reg && clean.ready && is_last;
    assign pop     = !q_stat.empty && (!busy_reg || done);

    assign clean.valid        = busy_reg;
    assign clean.out_byte     = pkt_reg.data[idx_reg];
    assign clean.was_replaced = pkt_reg.repl[idx_reg];
    assign clean.run_last     = is_last;
    assign clean.string_end   = is_last && pkt_reg.fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && clean.ready)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pkt_reg <= head;
        end
    end

endmodule

`default_nettype wire

/* hdl/u8s_checker.sv */
// Port-level checks for utf8_sanitizer_core and the bind that attaches them.
// Depends on utf8_sanitizer_core port names only.
`default_nettype none

module u8s_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       was_replaced,
    input wire logic       run_last,
    input wire logic       string_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(run_last) && $stable(string_end))
        else $error("output changed while stalled");

    a_repl_qmark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_replaced |-> out_byte == 8'h3F)
        else $error("replacement byte is not a question mark");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end not on last result of a transfer group");

    a_no_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_byte[7:3] != 5'b11111)
        else $error("invalid lead byte passed through");

endmodule

bind utf8_sanitizer_core u8s_checker u_u8s_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (clean.valid),
    .out_ready    (clean.ready),
    .out_byte     (clean.out_byte),
    .was_replaced (clean.was_replaced),
    .run_last     (clean.run_last),
    .string_end   (clean.string_end)
);

`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for utf8_sanitizer_core: directed and random byte streams.
// Depends on u8s_pkg, u8s_if and the RTL of utf8_sanitizer_core; predicts each
// cleaned byte and checks every output transfer against it in order.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 410;
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        u8s_pkg::byte_t b;
        logic           fin;
        logic           drain;
    } raw_item_t;

    typedef struct {
        u8s_pkg::byte_t out_byte;
        logic           was_replaced;
        logic           run_last;
        logic           string_end;
    } clean_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic           in_valid = 1'b0;
    u8s_pkg::byte_t in_byte = 8'h00;
    logic           in_end = 1'b0;
    logic           out_ready = 1'b0;

    u8s_in_if  raw_if ();
    u8s_out_if clean_if ();

    assign raw_if.valid   = in_valid;
    assign raw_if.in_byte = in_byte;
    assign raw_if.in_end  = in_end;
    assign clean_if.ready = out_ready;

    utf8_sanitizer_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .raw   (raw_if.sink),
        .clean (clean_if.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #400000;
        $display("FAIL utf8_sanitizer_core");
        $finish;
    end

    // Predictor state
    u8s_pkg::byte_t held_buf [3];
    int             held_cnt = 0;
    int             seq_need = 0;

    raw_item_t   pending_bytes [$];
    clean_byte_t expected_clean [$];
    clean_byte_t step_out [$];
    int          mismatches = 0;

    function automatic int lead_length(input u8s_pkg::byte_t b);
        int len;
        casez (b)
            8'b0???????: len = 1;
            8'b110?????: len = 2;
            8'b1110????: len = 3;
            8'b11110???: len = 4;
            default:     len = 0;
        endcase
        return len;
    endfunction

    function automatic void emit(input u8s_pkg::byte_t b, input logic repl);
        clean_byte_t cb;
        cb.out_byte     = b;
        cb.was_replaced = repl;
        cb.run_last     = 1'b0;
        cb.string_end   = 1'b0;
        step_out.insert(step_out.size(), cb);
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_cnt; i++)
        begin
            emit(u8s_pkg::QMARK, 1'b1);
        end
        held_cnt = 0;
        seq_need = 0;
    endfunction

    function automatic void sanitize_byte(input u8s_pkg::byte_t b, input logic fin);
        logic taken;
        int   len;
        taken = 1'b0;
        step_out.delete();
        if (held_cnt != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                taken = 1'b1;
                if (held_cnt + 1 >= seq_need)
                begin
                    for (int i = 0; i < held_cnt; i++)
                    begin
                        emit(held_buf[i], 1'b0);
                    end
                    emit(b, 1'b0);
                    held_cnt = 0;
                    seq_need = 0;
                end
                else
                begin
                    held_buf[held_cnt] = b;
                    held_cnt++;
                end
            end
            else
            begin
                flush_held();
            end
        end
        if (!taken)
        begin
            len = lead_length(b);
            if (len == 0)
            begin
                emit(u8s_pkg::QMARK, 1'b1);
            end
            else if (len == 1)
            begin
                emit(b, 1'b0);
            end
            else
            begin
                held_buf[0] = b;
                held_cnt = 1;
                seq_need = len;
            end
        end
        if (fin && held_cnt != 0)
        begin
            flush_held();
        end
        if (step_out.size() != 0)
        begin
            step_out[step_out.size() - 1].run_last   = 1'b1;
            step_out[step_out.size() - 1].string_end = fin;
        end
        foreach (step_out[i])
        begin
            expected_clean.insert(expected_clean.size(), step_out[i]);
        end
    endfunction

    task automatic report(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
        begin
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && raw_if.ready)
            begin
                sanitize_byte(in_byte, in_end);
            end
            if (!in_valid || raw_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].drain && expected_clean.size() != 0))
                begin
                    in_valid <= 1'b1;
                    in_byte  <= pending_bytes[0].b;
                    in_end   <= pending_bytes[0].fin;
                    void'(pending_bytes.pop_front());
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall mode re-chosen at random whenever the mode timer runs out
    int mode_timer = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_timer == 0)
            begin
                mode_timer <= 99;
                stall_mode <= $urandom_range(0, 2);
            end
            else
            begin
                mode_timer <= mode_timer - 1;
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready  <= 1'b0;
            end
            else if (stall_mode == 1 && $urandom_range(0, 2) == 0)
            begin
                stall_left <= $urandom_range(0, 2);
                out_ready  <= 1'b0;
            end
            else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
            begin
                stall_left <= $urandom_range(4, 12);
                out_ready  <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && clean_if.valid && out_ready)
        begin
            if (expected_clean.size() == 0)
            begin
                report("unexpected transfer, out_byte", int'(clean_if.out_byte), 0);
            end
            else
            begin
                if (clean_if.out_byte !== expected_clean[0].out_byte)
                begin
                    report("out_byte", int'(clean_if.out_byte),
                           int'(expected_clean[0].out_byte));
                end
                if (clean_if.was_replaced !== expected_clean[0].was_replaced)
                begin
                    report("was_replaced", int'(clean_if.was_replaced),
                           int'(expected_clean[0].was_replaced));
                end
                if (clean_if.run_last !== expected_clean[0].run_last)
                begin
                    report("run_last", int'(clean_if.run_last),
                           int'(expected_clean[0].run_last));
                end
                if (clean_if.string_end !== expected_clean[0].string_end)
                begin
                    report("string_end", int'(clean_if.string_end),
                           int'(expected_clean[0].string_end));
                end
                void'(expected_clean.pop_front());
            end
        end
    end

    // Stimulus
    function automatic void add_byte(input u8s_pkg::byte_t b, input logic fin,
                                     input logic drain = 1'b0);
        raw_item_t it;
        it.b     = b;
        it.fin   = fin;
        it.drain = drain;
        pending_bytes.insert(pending_bytes.size(), it);
    endfunction

    function automatic u8s_pkg::byte_t rand_lead(input int len);
        u8s_pkg::byte_t b;
        case (len)
            1:       b = u8s_pkg::byte_t'($urandom_range(8'h00, 8'h7F));
            2:       b = u8s_pkg::byte_t'($urandom_range(8'hC0, 8'hDF));
            3:       b = u8s_pkg::byte_t'($urandom_range(8'hE0, 8'hEF));
            default: b = u8s_pkg::byte_t'($urandom_range(8'hF0, 8'hF7));
        endcase
        return b;
    endfunction

    function automatic u8s_pkg::byte_t rand_cont();
        return u8s_pkg::byte_t'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic u8s_pkg::byte_t rand_non_cont();
        u8s_pkg::byte_t b;
        b = u8s_pkg::byte_t'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
        begin
            b[6] = 1'b1;
        end
        return b;
    endfunction

    initial
    begin
        int             kind;
        int             len;
        int             start;
        u8s_pkg::byte_t directed [$];

        // ASCII extremes, bad leads, each sequence length
        directed = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                     8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        foreach (directed[i])
        begin
            add_byte(directed[i], 1'b0);
        end
        // sequence broken by ASCII
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        // cut off by end of string
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        // lead alone at end of string
        add_byte(8'hC0, 1'b1);
        // full four-byte sequence ending the string
        add_byte(8'hF4, 1'b0);
        add_byte(8'h8F, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b1);
        // broken by a bad lead that also ends the string
        add_byte(8'hC2, 1'b0);
        add_byte(8'hFF, 1'b1);

        start = pending_bytes.size();
        pending_bytes[start - 1].fin = 1'b1;
        add_byte(8'h41, 1'b0, 1'b1);
        while (pending_bytes.size() - start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 60)
            begin
                len = $urandom_range(1, 4);
                add_byte(rand_lead(len), 1'b0, $urandom_range(0, 39) == 0);
                for (int i = 1; i < len; i++)
                begin
                    add_byte(rand_cont(), 1'b0);
                end
            end
            else if (kind < 82)
            begin
                len = $urandom_range(2, 4);
                add_byte(rand_lead(len), 1'b0);
                for (int i = $urandom_range(0, len - 2); i > 0; i--)
                begin
                    add_byte(rand_cont(), 1'b0);
                end
                if (kind < 72)
                begin
                    add_byte(rand_non_cont(), 1'b0);
                end
                else
                begin
                    pending_bytes[pending_bytes.size() - 1].fin = 1'b1;
                end
            end
            else if (kind < 92)
            begin
                add_byte(u8s_pkg::byte_t'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
            else
            begin
                add_byte(($urandom_range(0, 1) == 0) ? rand_cont()
                                                     : u8s_pkg::byte_t'($urandom_range(8'hF8, 8'hFF)),
                         1'b0);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                pending_bytes[pending_bytes.size() - 1].fin = 1'b1;
            end
        end
        pending_bytes[pending_bytes.size() - 1].fin = 1'b1;

        @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_clean.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS utf8_sanitizer_core");
        end
        else
        begin
            $display("FAIL utf8_sanitizer_core");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/u8s_pkg.sv
hdl/u8s_if.sv
hdl/u8s_front.sv
hdl/u8s_queue.sv
hdl/u8s_back.sv
hdl/utf8_sanitizer_core.sv
hdl/u8s_checker.sv
dv/tb_top.sv
